### hw/rtl/pgs_pkg.sv
// Package with the types, constants and step functions of the polar Gaussian sampler.
`default_nettype none
package pgs_pkg;

  localparam int unsigned LogBits   = 26;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 30;

  localparam logic [30:0] TwoLn2Q30 = 31'd1488522236;

  localparam logic CfgMean = 1'b0;
  localparam logic CfgStd  = 1'b1;

  typedef struct packed {
    logic [31:0] u_word;
    logic [31:0] v_word;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [30:0] ush;
    logic [30:0] vsh;
    logic        un;
    logic        vn;
  } carry_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_t;

  function automatic logic [31:0] word_mag(logic [31:0] w);
    if (w[31]) begin
      return {1'b0, w[30:0]};
    end
    return 32'h8000_0000 - w;
  endfunction

  function automatic logic [5:0] top_bit(logic [61:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 62; i++) begin
      if (x[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  // Returns the next aligned value in the upper bits and the new fraction bit in bit 0.
  function automatic logic [31:0] log_step(logic [30:0] y);
    logic [61:0] sq;
    logic [31:0] t;
    sq = y * y;
    t  = sq[61:30];
    if (t[31]) begin
      return {t[31:1], 1'b1};
    end
    return {t[30:0], 1'b0};
  endfunction

  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t       r;
    logic [34:0] rem2;
    logic [34:0] trial;
    rem2  = {s.rem[32:0], s.rad[63:62]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // Returns the next remainder in the upper bits and the quotient bit in bit 0.
  function automatic logic [64:0] div_step(logic [63:0] rem, logic [34:0] den,
                                           logic [4:0] shamt);
    logic [64:0] dsh;
    dsh = 65'(den) << shamt;
    if ({1'b0, rem} >= dsh) begin
      return {rem - dsh[63:0], 1'b1};
    end
    return {rem, 1'b0};
  endfunction

  function automatic logic signed [31:0] sat_sample(logic signed [31:0] mean,
                                                    logic [37:0] t, logic neg);
    logic signed [39:0] s;
    if (neg) begin
      s = 40'(mean) - $signed({2'b00, t});
    end else begin
      s = 40'(mean) + $signed({2'b00, t});
    end
    if (s > 40'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (s < -40'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/polar_gaussian_sampler.sv
// Top level of the polar Gaussian sampler: a deep pipeline from uniform pairs to two samples.
`default_nettype none
// Each transfer in carries two uniform words; a pair that falls outside the unit circle (or on
// its center) is dropped, any other pair gives two Q8.24 samples, the second marked last. A
// new pair can enter in every cycle while the pipeline is not stalled, so when every pair is
// kept the sustained rate is set by the output channel, which sends each pair as two samples.
// Each pair passes 26 logarithm stages, 32 square root stages, 30 divider stages and 11 other
// pipeline stages before the output register. Registers must be written only while the
// pipeline is empty.
module polar_gaussian_sampler import pgs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  logic signed [31:0] mean_q;
  logic [30:0]        std_q;

  logic adv;

  logic        v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, vp_q, vd_q, vt_q, vf_q;
  logic [31:0] um0_q, vm0_q, um1_q, vm1_q, um2_q, vm2_q, um3_q, vm3_q;
  logic        un0_q, vn0_q, un1_q, vn1_q, un2_q, vn2_q, un3_q, vn3_q;
  logic [63:0] uu1_q, vv1_q;
  logic [61:0] r2_2_q, r2_3_q;
  logic [63:0] r2_sum;
  logic        reject;
  logic [5:0]  p3_q, p4_q;
  logic [30:0] y4_q;
  carry_t      c4_q, c4_d;
  logic [4:0]  k3;
  logic [61:0] y_wide;
  logic [63:0] ush_w, vsh_w;

  logic              lv_q [LogBits];
  logic [30:0]       ly_q [LogBits];
  logic [LogBits-1:0] lf_q [LogBits];
  logic [5:0]        lp_q [LogBits];
  carry_t            lc_q [LogBits];
  logic [31:0]       lstep [LogBits];

  logic [31:0] nl5_q;
  carry_t      c5_q, c6_q;
  logic [32:0] a6_q;
  logic [62:0] aprod;
  logic [63:0] asum;

  logic        qv_q [SqrtSteps];
  sqrt_t       qa_q [SqrtSteps];
  sqrt_t       qb_q [SqrtSteps];
  carry_t      qc_q [SqrtSteps];
  sqrt_t       qa_d [SqrtSteps];
  sqrt_t       qb_d [SqrtSteps];
  sqrt_t       qa_in, qb_in;

  logic [62:0] nump_u_q, nump_v_q;
  logic [30:0] sqp_q;
  logic        unp_q, vnp_q;
  logic [63:0] dd_u_q, dd_v_q;
  logic [34:0] dden_q;
  logic        und_q, vnd_q;

  logic              dv_q [DivSteps];
  logic [63:0]       dru_q [DivSteps];
  logic [63:0]       drv_q [DivSteps];
  logic [DivSteps-1:0] dqu_q [DivSteps];
  logic [DivSteps-1:0] dqv_q [DivSteps];
  logic [34:0]       dden_s_q [DivSteps];
  logic              dun_q [DivSteps];
  logic              dvn_q [DivSteps];
  logic [64:0]       dsu [DivSteps];
  logic [64:0]       dsv [DivSteps];

  logic [37:0] tu_q, tv_q;
  logic        unt_q, vnt_q;
  logic [61:0] tu_sum, tv_sum;
  logic signed [31:0] su_q, sv_q;

  logic               ov_q, phase_q;
  logic signed [31:0] o0_q, o1_q;
  logic               can_load, out_xfer;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      std_q  <= 31'd16777216;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMean: mean_q <= $signed(cfg_data_i);
        CfgStd:  std_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign out_xfer   = ov_q && !out_stall_i;
  assign can_load   = !ov_q || (phase_q && !out_stall_i);
  assign adv        = !vf_q || can_load;
  assign in_stall_o = !adv;

  always_comb begin
    r2_sum = uu1_q + vv1_q;
    reject = (r2_sum == '0) || (r2_sum[63:62] != 2'b00);
    k3     = 5'((6'd61 - p3_q) >> 1);
    if (p3_q >= 6'd30) begin
      y_wide = r2_3_q >> (p3_q - 6'd30);
    end else begin
      y_wide = r2_3_q << (6'd30 - p3_q);
    end
    ush_w    = {32'b0, um3_q} << k3;
    vsh_w    = {32'b0, vm3_q} << k3;
    c4_d.rad = {2'b00, r2_3_q} << {k3, 1'b0};
    c4_d.ush = ush_w[30:0];
    c4_d.vsh = vsh_w[30:0];
    c4_d.un  = un3_q;
    c4_d.vn  = vn3_q;
  end

  always_comb begin
    lstep[0] = log_step(y4_q);
    for (int i = 1; i < LogBits; i++) begin
      lstep[i] = log_step(ly_q[i-1]);
    end
  end

  assign aprod = nl5_q * TwoLn2Q30;
  assign asum  = {1'b0, aprod} + 64'h2000_0000;

  always_comb begin
    qa_in.rad  = {a6_q[32:0], 31'b0} >> 1;
    qa_in.rem  = '0;
    qa_in.root = '0;
    qb_in.rad  = c6_q.rad;
    qb_in.rem  = '0;
    qb_in.root = '0;
    qa_d[0] = sqrt_step(qa_in);
    qb_d[0] = sqrt_step(qb_in);
    for (int i = 1; i < SqrtSteps; i++) begin
      qa_d[i] = sqrt_step(qa_q[i-1]);
      qb_d[i] = sqrt_step(qb_q[i-1]);
    end
  end

  always_comb begin
    dsu[0] = div_step(dd_u_q, dden_q, 5'(DivSteps - 1));
    dsv[0] = div_step(dd_v_q, dden_q, 5'(DivSteps - 1));
    for (int i = 1; i < DivSteps; i++) begin
      dsu[i] = div_step(dru_q[i-1], dden_s_q[i-1], 5'(DivSteps - 1 - i));
      dsv[i] = div_step(drv_q[i-1], dden_s_q[i-1], 5'(DivSteps - 1 - i));
    end
  end

  assign tu_sum = 62'(std_q * dqu_q[DivSteps-1]) + 62'h80_0000;
  assign tv_sum = 62'(std_q * dqv_q[DivSteps-1]) + 62'h80_0000;

  // Valid bits travel with the data and only move when the whole pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vp_q <= 1'b0;
      vd_q <= 1'b0;
      vt_q <= 1'b0;
      vf_q <= 1'b0;
      for (int i = 0; i < LogBits; i++) begin
        lv_q[i] <= 1'b0;
      end
      for (int i = 0; i < SqrtSteps; i++) begin
        qv_q[i] <= 1'b0;
      end
      for (int i = 0; i < DivSteps; i++) begin
        dv_q[i] <= 1'b0;
      end
    end else if (adv) begin
      v0_q    <= in_valid_i;
      v1_q    <= v0_q;
      v2_q    <= v1_q && !reject;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      lv_q[0] <= v4_q;
      for (int i = 1; i < LogBits; i++) begin
        lv_q[i] <= lv_q[i-1];
      end
      v5_q    <= lv_q[LogBits-1];
      v6_q    <= v5_q;
      qv_q[0] <= v6_q;
      for (int i = 1; i < SqrtSteps; i++) begin
        qv_q[i] <= qv_q[i-1];
      end
      vp_q    <= qv_q[SqrtSteps-1];
      vd_q    <= vp_q;
      dv_q[0] <= vd_q;
      for (int i = 1; i < DivSteps; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
      vt_q <= dv_q[DivSteps-1];
      vf_q <= vt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      um0_q <= word_mag(in_data_i.u_word);
      vm0_q <= word_mag(in_data_i.v_word);
      un0_q <= !in_data_i.u_word[31];
      vn0_q <= !in_data_i.v_word[31];

      uu1_q <= um0_q * um0_q;
      vv1_q <= vm0_q * vm0_q;
      um1_q <= um0_q;
      vm1_q <= vm0_q;
      un1_q <= un0_q;
      vn1_q <= vn0_q;

      r2_2_q <= r2_sum[61:0];
      um2_q  <= um1_q;
      vm2_q  <= vm1_q;
      un2_q  <= un1_q;
      vn2_q  <= vn1_q;

      p3_q   <= top_bit(r2_2_q);
      r2_3_q <= r2_2_q;
      um3_q  <= um2_q;
      vm3_q  <= vm2_q;
      un3_q  <= un2_q;
      vn3_q  <= vn2_q;

      y4_q <= y_wide[30:0];
      p4_q <= p3_q;
      c4_q <= c4_d;

      ly_q[0] <= lstep[0][31:1];
      lf_q[0] <= {{(LogBits-1){1'b0}}, lstep[0][0]};
      lp_q[0] <= p4_q;
      lc_q[0] <= c4_q;
      for (int i = 1; i < LogBits; i++) begin
        ly_q[i] <= lstep[i][31:1];
        lf_q[i] <= {lf_q[i-1][LogBits-2:0], lstep[i][0]};
        lp_q[i] <= lp_q[i-1];
        lc_q[i] <= lc_q[i-1];
      end

      nl5_q <= {6'd62 - lp_q[LogBits-1], 26'b0} - 32'(lf_q[LogBits-1]);
      c5_q  <= lc_q[LogBits-1];

      a6_q <= asum[62:30];
      c6_q <= c5_q;

      qa_q[0] <= qa_d[0];
      qb_q[0] <= qb_d[0];
      qc_q[0] <= c6_q;
      for (int i = 1; i < SqrtSteps; i++) begin
        qa_q[i] <= qa_d[i];
        qb_q[i] <= qb_d[i];
        qc_q[i] <= qc_q[i-1];
      end

      nump_u_q <= qc_q[SqrtSteps-1].ush * qa_q[SqrtSteps-1].root;
      nump_v_q <= qc_q[SqrtSteps-1].vsh * qa_q[SqrtSteps-1].root;
      sqp_q    <= qb_q[SqrtSteps-1].root[30:0];
      unp_q    <= qc_q[SqrtSteps-1].un;
      vnp_q    <= qc_q[SqrtSteps-1].vn;

      dd_u_q <= {1'b0, nump_u_q} + {30'b0, sqp_q, 3'b000};
      dd_v_q <= {1'b0, nump_v_q} + {30'b0, sqp_q, 3'b000};
      dden_q <= {sqp_q, 4'b0000};
      und_q  <= unp_q;
      vnd_q  <= vnp_q;

      dru_q[0]    <= dsu[0][64:1];
      drv_q[0]    <= dsv[0][64:1];
      dqu_q[0]    <= {{(DivSteps-1){1'b0}}, dsu[0][0]};
      dqv_q[0]    <= {{(DivSteps-1){1'b0}}, dsv[0][0]};
      dden_s_q[0] <= dden_q;
      dun_q[0]    <= und_q;
      dvn_q[0]    <= vnd_q;
      for (int i = 1; i < DivSteps; i++) begin
        dru_q[i]    <= dsu[i][64:1];
        drv_q[i]    <= dsv[i][64:1];
        dqu_q[i]    <= {dqu_q[i-1][DivSteps-2:0], dsu[i][0]};
        dqv_q[i]    <= {dqv_q[i-1][DivSteps-2:0], dsv[i][0]};
        dden_s_q[i] <= dden_s_q[i-1];
        dun_q[i]    <= dun_q[i-1];
        dvn_q[i]    <= dvn_q[i-1];
      end

      tu_q  <= tu_sum[61:24];
      tv_q  <= tv_sum[61:24];
      unt_q <= dun_q[DivSteps-1];
      vnt_q <= dvn_q[DivSteps-1];

      su_q <= sat_sample(mean_q, tu_q, unt_q);
      sv_q <= sat_sample(mean_q, tv_q, vnt_q);
    end
  end

  // The output register holds one sample pair and sends the first, then the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (out_xfer) begin
        if (phase_q) begin
          ov_q    <= 1'b0;
          phase_q <= 1'b0;
        end else begin
          phase_q <= 1'b1;
        end
      end
      if (adv && vf_q) begin
        ov_q    <= 1'b1;
        phase_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vf_q) begin
      o0_q <= su_q;
      o1_q <= sv_q;
    end
  end

  assign out_valid_o       = ov_q;
  assign out_data_o.sample = phase_q ? o1_q : o0_q;
  assign out_data_o.last   = phase_q;

endmodule
`default_nettype wire

### test/polar_gaussian_sampler_test.sv
// Testbench for the polar Gaussian sampler: checks every sample against a predictor.
module polar_gaussian_sampler_test;
  import pgs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CfgMean;
  logic [31:0] cfg_data_i = '0;

  longint          mean_q;
  longint unsigned std_q;
  out_t            pending_samples[$];
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  bit              failed = 1'b0;

  polar_gaussian_sampler uut (.*);

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] scaled_sample(longint unsigned mag, bit neg, int k,
                                                       longint unsigned sa,
                                                       longint unsigned sq);
    longint unsigned den, x, t;
    longint          s;
    den = sq << 4;
    x = ((mag << k) * sa + (den >> 1)) / den;
    t = (std_q * x + (64'd1 << 23)) >> 24;
    s = neg ? mean_q - longint'(t) : mean_q + longint'(t);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  // Appends the two samples of a kept pair; a rejected pair adds nothing.
  task automatic predict_pair(in_t item);
    longint unsigned um, vm, r2, y, frac, nl, a, sa, sq;
    bit              un, vn;
    int              p, k;
    out_t            o;
    un = !item.u_word[31];
    vn = !item.v_word[31];
    um = un ? 64'h8000_0000 - item.u_word : item.u_word - 64'h8000_0000;
    vm = vn ? 64'h8000_0000 - item.v_word : item.v_word - 64'h8000_0000;
    r2 = um * um + vm * vm;
    if (r2 == 0 || r2 >= (64'd1 << 62)) return;
    p = 0;
    while (p < 63 && (r2 >> (p + 1)) != 0) p++;
    y = (p >= 30) ? (r2 >> (p - 30)) : (r2 << (30 - p));
    frac = 0;
    for (int i = 0; i < 26; i++) begin
      y = (y * y) >> 30;
      frac <<= 1;
      if (y >= (64'd1 << 31)) begin
        y >>= 1;
        frac |= 1;
      end
    end
    nl = (longint'(62 - p) << 26) - frac;
    a = (nl * 64'd1488522236 + (64'd1 << 29)) >> 30;
    sa = int_sqrt(a << 30);
    k = (61 - p) / 2;
    sq = int_sqrt(r2 << (2 * k));
    o.sample = scaled_sample(um, un, k, sa, sq);
    o.last = 1'b0;
    pending_samples.push_back(o);
    o.sample = scaled_sample(vm, vn, k, sa, sq);
    o.last = 1'b1;
    pending_samples.push_back(o);
  endtask

  task automatic send_pair(logic [31:0] u, logic [31:0] v);
    in_t item;
    item.u_word = u;
    item.v_word = v;
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_pair(item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMean) mean_q = longint'(signed'(value));
    else std_q = value[30:0];
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] off;
    off = $urandom() >> $urandom_range(31);
    return $urandom_range(1) ? 32'h8000_0000 + off : 32'h8000_0000 - off;
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected sample %0d", out_data_o.sample);
        failed = 1'b1;
      end else begin
        out_t e;
        e = pending_samples.pop_front();
        if (out_data_o.sample !== e.sample) begin
          $error("sample: expected %0d, got %0d", e.sample, out_data_o.sample);
          failed = 1'b1;
        end
        if (out_data_o.last !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, out_data_o.last);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic test_special_pairs();
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0000_0001, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'hFFFF_FFFF);
    send_pair(32'h8000_0001, 32'h8000_0000);
    send_pair(32'h7FFF_FFFF, 32'h8000_0001);
    send_pair(32'hA000_0000, 32'h6000_0000);
    send_pair(32'hFFFF_FFFF, 32'h8000_0000);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA);
    drain();
  endtask

  task automatic test_saturation();
    write_reg(CfgMean, 32'h7FFF_FFFF);
    write_reg(CfgStd, 32'hFFFF_FFFF);
    send_pair(32'h8000_0001, 32'h7FFF_FFFF);
    send_pair(32'hC000_0000, 32'h4000_0000);
    drain();
    write_reg(CfgMean, 32'h8000_0000);
    send_pair(32'h8000_0001, 32'h7FFF_FFFF);
    send_pair(32'h4000_0000, 32'hC000_0000);
    drain();
    write_reg(CfgStd, 32'h0000_0000);
    send_pair(32'h9000_0000, 32'h7000_0000);
    drain();
  endtask

  task automatic test_random_pairs();
    int modes[3][2] = '{'{12, 62}, '{62, 12}, '{0, 0}};
    for (int m = 0; m < 3; m++) begin
      write_reg(CfgMean, $urandom());
      write_reg(CfgStd, $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0400_0000));
      send_idle_pct = modes[m][0];
      recv_idle_pct = modes[m][1];
      repeat (560) begin
        if ($urandom_range(3) == 0) send_pair($urandom(), $urandom());
        else send_pair(rand_word(), rand_word());
      end
      drain();
    end
  endtask

  initial begin
    mean_q = 0;
    std_q = 64'd16777216;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_pairs();
    test_saturation();
    test_random_pairs();
    if (!failed && pending_samples.size() == 0) begin
      $display("polar_gaussian_sampler: match");
    end else begin
      $display("polar_gaussian_sampler: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("polar_gaussian_sampler: mismatch");
    $finish;
  end
endmodule
